// ===== hdl/csd_pkg.sv =====
`default_nettype none
package csd_pkg;

	localparam int LANES_DEF  = 3;
	localparam int OUT_LANES  = 3;
	localparam int HL_W       = 24;
	localparam int THR_W      = 16;
	localparam int DT_W       = 16;

	localparam logic [HL_W-1:0]  HALF_LIFE_RST = 24'd6554;
	localparam logic [THR_W-1:0] THRESH_RST    = 16'd7;

	// register indexes on the configuration port
	localparam logic REG_HALF_LIFE = 1'b0;
	localparam logic REG_THRESHOLD = 1'b1;

	// 2*ln2 in Q.24 scaled by 2^16 (ln2 in Q.64 shifted right by 23)
	localparam logic [63:0] LN2X2_Q24 = 64'hB17217F7D1CF79AB >> 23;
	localparam logic [63:0] C048_Q24  = 64'd8053064;
	localparam logic [63:0] C0235_Q24 = 64'd3942646;
	localparam logic [63:0] X_MAX_Q24 = 64'd4096 << 24;
	localparam logic [63:0] ONE_Q24   = 64'd1 << 24;
	localparam logic [63:0] DECAY_NUM = 64'd1 << 56;
	localparam logic [63:0] MAG_CAP   = 64'd1 << 61;

	typedef enum logic [1:0] {SH_16, SH_24, SH_32} shift_t;

	typedef struct packed {
		logic        start;
		logic [63:0] a;
		logic [63:0] b;
		shift_t      sh;
	} mul_req_t;

	typedef struct packed {
		logic        start;
		logic [63:0] num;
		logic [63:0] den;
	} div_req_t;

	typedef enum logic [3:0] {
		C_IDLE, C_Y, C_X, C_X2, C_X3, C_T48, C_T235, C_DEC
	} coef_state_t;

	typedef enum logic [2:0] {
		L_IDLE, L_P1, L_P2, L_P3, L_P4, L_P5, L_P6
	} lane_state_t;

	typedef enum logic [1:0] {T_IDLE, T_COEF, T_LANE, T_PUSH} top_state_t;

	function automatic logic [63:0] mag64(input logic signed [63:0] v);
		return v[63] ? 64'(-v) : 64'(v);
	endfunction

	function automatic logic signed [63:0] sgn64(input logic [63:0] m, input logic neg);
		return neg ? -$signed(m) : $signed(m);
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
		if (v > 64'sd2147483647)
			return 32'sh7FFFFFFF;
		else if (v < -64'sd2147483648)
			return 32'sh80000000;
		else
			return v[31:0];
	endfunction

endpackage
`default_nettype wire

// ===== hdl/csd_mul.sv =====
`default_nettype none
module csd_mul (
	input  logic              clk,
	input  logic              arst_n,
	input  csd_pkg::mul_req_t req,
	output logic              done,
	output logic [63:0]       res
);
	import csd_pkg::*;

	logic         busy_q, pv_q, fin_q, done_q;
	logic [1:0]   cnt_q, pidx_q;
	logic [63:0]  a_q, b_q, prod_q, res_q;
	shift_t       sh_q;
	logic [127:0] acc_q, part, shifted;
	logic [31:0]  op_a, op_b;

	// pick one 32x32 partial product per cycle
	assign op_a = cnt_q[1] ? a_q[63:32] : a_q[31:0];
	assign op_b = cnt_q[0] ? b_q[63:32] : b_q[31:0];

	always_comb begin
		unique case (pidx_q)
			2'd0:    part = {64'd0, prod_q};
			2'd3:    part = {prod_q, 64'd0};
			default: part = {32'd0, prod_q, 32'd0};
		endcase
	end

	always_comb begin
		unique case (sh_q)
			SH_16:   shifted = acc_q >> 16;
			SH_24:   shifted = acc_q >> 24;
			default: shifted = acc_q >> 32;
		endcase
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			pv_q   <= 1'b0;
			fin_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			pidx_q <= '0;
		end else begin
			done_q <= fin_q;
			fin_q  <= pv_q && (pidx_q == 2'd3);
			pv_q   <= busy_q;
			if (busy_q) begin
				pidx_q <= cnt_q;
				cnt_q  <= cnt_q + 2'd1;
				if (cnt_q == 2'd3)
					busy_q <= 1'b0;
			end
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end
		end
	end

	// datapath: multiply, accumulate, shift and cap
	always_ff @(posedge clk) begin
		if (req.start) begin
			a_q   <= req.a;
			b_q   <= req.b;
			sh_q  <= req.sh;
			acc_q <= '0;
		end else if (pv_q) begin
			acc_q <= acc_q + part;
		end
		if (busy_q)
			prod_q <= op_a * op_b;
		if (fin_q) begin
			if ((|shifted[127:62]) || (shifted[61] && (|shifted[60:0])))
				res_q <= MAG_CAP;
			else
				res_q <= shifted[63:0];
		end
	end

	assign done = done_q;
	assign res  = res_q;

endmodule
`default_nettype wire

// ===== hdl/csd_div.sv =====
`default_nettype none
module csd_div (
	input  logic              clk,
	input  logic              arst_n,
	input  csd_pkg::div_req_t req,
	output logic              done,
	output logic [63:0]       quo
);
	import csd_pkg::*;

	logic        busy_q, done_q;
	logic [5:0]  cnt_q;
	logic [63:0] rem_q, q_q, den_q;
	logic [64:0] shl, trial;

	assign shl   = {rem_q, q_q[63]};
	assign trial = shl - {1'b0, den_q};

	// control: one quotient bit a cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == 6'd63);
			if (busy_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'd63)
					busy_q <= 1'b0;
			end
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end
		end
	end

	// restoring step
	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			q_q   <= req.num;
			den_q <= req.den;
		end else if (busy_q) begin
			if (!trial[64]) begin
				rem_q <= trial[63:0];
				q_q   <= {q_q[62:0], 1'b1};
			end else begin
				rem_q <= shl[63:0];
				q_q   <= {q_q[62:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign quo  = q_q;

endmodule
`default_nettype wire

// ===== hdl/csd_coef.sv =====
`default_nettype none
module csd_coef (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [csd_pkg::HL_W-1:0]      half_life,
	input  logic [csd_pkg::DT_W-1:0]      time_step,
	output logic                          done,
	output logic [63:0]                   y,
	output logic [63:0]                   decay
);
	import csd_pkg::*;

	coef_state_t state_q, state_d;
	mul_req_t    mreq;
	div_req_t    dreq;
	logic        mdone, ddone, done_q;
	logic [63:0] mres, dquo, xc;
	logic [63:0] y_q, x_q, x2_q, x3_q, t48_q, decay_q;

	csd_mul u_mul (.clk(clk), .arst_n(arst_n), .req(mreq), .done(mdone), .res(mres));
	csd_div u_div (.clk(clk), .arst_n(arst_n), .req(dreq), .done(ddone), .quo(dquo));

	assign xc = (mres > X_MAX_Q24) ? X_MAX_Q24 : mres;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= C_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= (state_q == C_DEC) && ddone;
		end
	end

	// sequence the coefficient chain through the shared multiplier and divider
	always_comb begin
		state_d = state_q;
		mreq    = '{start: 1'b0, a: 64'd0, b: 64'd0, sh: SH_24};
		dreq    = '{start: 1'b0, num: LN2X2_Q24, den: 64'(half_life) + 64'd1};
		unique case (state_q)
			C_IDLE: if (start) begin
				dreq.start = 1'b1;
				state_d    = C_Y;
			end
			C_Y: if (ddone) begin
				mreq    = '{start: 1'b1, a: dquo, b: 64'(time_step), sh: SH_16};
				state_d = C_X;
			end
			C_X: if (mdone) begin
				mreq    = '{start: 1'b1, a: xc, b: xc, sh: SH_24};
				state_d = C_X2;
			end
			C_X2: if (mdone) begin
				mreq    = '{start: 1'b1, a: mres, b: x_q, sh: SH_24};
				state_d = C_X3;
			end
			C_X3: if (mdone) begin
				mreq    = '{start: 1'b1, a: x2_q, b: C048_Q24, sh: SH_24};
				state_d = C_T48;
			end
			C_T48: if (mdone) begin
				mreq    = '{start: 1'b1, a: x3_q, b: C0235_Q24, sh: SH_24};
				state_d = C_T235;
			end
			C_T235: if (mdone) begin
				dreq    = '{start: 1'b1, num: DECAY_NUM,
					den: ONE_Q24 + x_q + t48_q + mres};
				state_d = C_DEC;
			end
			C_DEC: if (ddone)
				state_d = C_IDLE;
			default: state_d = C_IDLE;
		endcase
	end

	// capture intermediate terms
	always_ff @(posedge clk) begin
		if (state_q == C_Y && ddone)
			y_q <= dquo;
		if (state_q == C_X && mdone)
			x_q <= xc;
		if (state_q == C_X2 && mdone)
			x2_q <= mres;
		if (state_q == C_X3 && mdone)
			x3_q <= mres;
		if (state_q == C_T48 && mdone)
			t48_q <= mres;
		if (state_q == C_DEC && ddone)
			decay_q <= dquo;
	end

	assign done  = done_q;
	assign y     = y_q;
	assign decay = decay_q;

endmodule
`default_nettype wire

// ===== hdl/csd_lane.sv =====
`default_nettype none
module csd_lane (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic                       func,
	input  logic                       hold,
	input  logic signed [31:0]         target,
	input  logic [csd_pkg::DT_W-1:0]   time_step,
	input  logic [csd_pkg::THR_W-1:0]  threshold,
	input  logic [63:0]                y,
	input  logic [63:0]                decay,
	output logic                       done,
	output logic signed [31:0]         pos,
	output logic signed [31:0]         vel
);
	import csd_pkg::*;

	lane_state_t       state_q, state_d;
	mul_req_t          mreq;
	logic              mdone, done_q, done_d, neg_q, neg_d, rest;
	logic [63:0]       mres;
	logic signed [63:0] prod, t64, v64, j0, j1_c, a_c, b_c;
	logic signed [63:0] j0_q, j1_q, a_q, b_q;
	logic signed [31:0] pos_q, vel_q, pn_q, pn_c, vn_c;
	logic [63:0]       thr64;

	csd_mul u_mul (.clk(clk), .arst_n(arst_n), .req(mreq), .done(mdone), .res(mres));

	assign t64   = 64'(target);
	assign v64   = 64'(vel_q);
	assign j0    = 64'(pos_q) - t64;
	assign thr64 = 64'(threshold);
	assign rest  = (mag64(j0) < thr64) && (v64 < $signed(thr64));
	assign prod  = sgn64(mres, neg_q);
	assign j1_c  = v64 + prod;
	assign a_c   = j0_q + prod;
	assign b_c   = v64 - prod;
	assign pn_c  = sat32(prod + t64);
	assign vn_c  = sat32(prod);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= L_IDLE;
			done_q  <= 1'b0;
			pos_q   <= '0;
			vel_q   <= '0;
		end else begin
			state_q <= state_d;
			done_q  <= done_d;
			if (state_q == L_IDLE && start && !hold && func) begin
				pos_q <= target;
				vel_q <= '0;
			end
			if (state_q == L_P6 && mdone) begin
				pos_q <= pn_q;
				vel_q <= vn_c;
			end
		end
	end

	// step through the six signed products of the update
	always_comb begin
		state_d = state_q;
		done_d  = 1'b0;
		neg_d   = neg_q;
		mreq    = '{start: 1'b0, a: 64'd0, b: 64'd0, sh: SH_24};
		unique case (state_q)
			L_IDLE: if (start) begin
				if (hold || func || rest) begin
					done_d = 1'b1;
				end else begin
					mreq    = '{start: 1'b1, a: mag64(j0), b: y, sh: SH_24};
					neg_d   = j0[63];
					state_d = L_P1;
				end
			end
			L_P1: if (mdone) begin
				mreq    = '{start: 1'b1, a: mag64(j1_c), b: 64'(time_step), sh: SH_16};
				neg_d   = j1_c[63];
				state_d = L_P2;
			end
			L_P2: if (mdone) begin
				mreq    = '{start: 1'b1, a: mag64(j1_q), b: y, sh: SH_24};
				neg_d   = j1_q[63];
				state_d = L_P3;
			end
			L_P3: if (mdone) begin
				mreq    = '{start: 1'b1, a: mres, b: 64'(time_step), sh: SH_16};
				state_d = L_P4;
			end
			L_P4: if (mdone) begin
				mreq    = '{start: 1'b1, a: mag64(a_q), b: decay, sh: SH_32};
				neg_d   = a_q[63];
				state_d = L_P5;
			end
			L_P5: if (mdone) begin
				mreq    = '{start: 1'b1, a: mag64(b_q), b: decay, sh: SH_32};
				neg_d   = b_q[63];
				state_d = L_P6;
			end
			L_P6: if (mdone) begin
				done_d  = 1'b1;
				state_d = L_IDLE;
			end
			default: state_d = L_IDLE;
		endcase
	end

	// hold intermediate terms
	always_ff @(posedge clk) begin
		neg_q <= neg_d;
		if (state_q == L_IDLE)
			j0_q <= j0;
		if (state_q == L_P1 && mdone)
			j1_q <= j1_c;
		if (state_q == L_P2 && mdone)
			a_q <= a_c;
		if (state_q == L_P4 && mdone)
			b_q <= b_c;
		if (state_q == L_P5 && mdone)
			pn_q <= pn_c;
	end

	assign done = done_q;
	assign pos  = pos_q;
	assign vel  = vel_q;

endmodule
`default_nettype wire

// ===== hdl/critically_damped_spring_step.sv =====
// Critically damped spring, up to three lanes stepped per transfer.
// Input stream: one transfer carries the three lane targets, the time step
// and the hold mask in s_axis_tdata, and func in s_axis_tuser (0 = step the
// spring, 1 = snap each unheld lane to its target with zero velocity).
// Output stream: one transfer per input with the new positions and
// velocities of all lanes, saturated to 32 bit signed.
// Configuration: APB registers half_life (0x0) and settle_threshold (0x4);
// write them only while the block is idle.
// Flow: one item at a time. The coefficient unit runs first
// (two 64-step restoring divisions plus five 4-partial multiplies), then
// the lanes run in parallel for up to six multiplies each; a lane that is
// held, snapped or at rest skips its multiplies.
// s_axis_tready is high only when no item is in work; a finished result
// waits in the output register, and the next item may be accepted while it
// waits. If the receiver stalls, a second finished result holds in the
// lanes until the output register frees.
// Reset clears lane positions and velocities to zero and loads the
// register defaults (half_life 6554, settle_threshold 7).
`default_nettype none
module critically_damped_spring_step #(
	parameter int LANES = csd_pkg::LANES_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	// s_axis_tdata: target_x[31:0], target_y[63:32], target_z[95:64],
	//               time_step[111:96], hold_mask[114:112], zero pad
	input  logic          s_axis_tvalid,
	output logic          s_axis_tready,
	input  logic [119:0]  s_axis_tdata,
	// s_axis_tuser: func[0]
	input  logic [0:0]    s_axis_tuser,
	output logic          m_axis_tvalid,
	input  logic          m_axis_tready,
	// m_axis_tdata: pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, 32 bits each from bit 0
	output logic [191:0]  m_axis_tdata,
	input  logic          psel,
	input  logic          penable,
	input  logic          pwrite,
	input  logic [2:0]    paddr,
	input  logic [31:0]   pwdata,
	output logic [31:0]   prdata,
	output logic          pready
);
	import csd_pkg::*;

	localparam int NUM_LANES = (LANES < OUT_LANES) ? LANES : OUT_LANES;

	top_state_t            state_q, state_d;
	logic [HL_W-1:0]       half_life_q;
	logic [THR_W-1:0]      thr_q;
	logic                  func_q;
	logic [2:0]            hold_q;
	logic [DT_W-1:0]       dt_q;
	logic [95:0]           tgt_q;
	logic                  coef_start, coef_done, lane_start, all_done, load_out;
	logic [63:0]           y, decay;
	logic [NUM_LANES-1:0]  lane_done, ldone_q;
	logic [191:0]          out_q, result;
	logic                  out_valid_q;
	logic [31:0]           pos_w [OUT_LANES];
	logic [31:0]           vel_w [OUT_LANES];

	assign pready = 1'b1;

	// configuration writes and reads
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_life_q <= HALF_LIFE_RST;
			thr_q       <= THRESH_RST;
		end else if (psel && penable && pwrite) begin
			unique case (paddr[2])
				REG_HALF_LIFE: half_life_q <= pwdata[HL_W-1:0];
				REG_THRESHOLD: thr_q       <= pwdata[THR_W-1:0];
				default:       ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_HALF_LIFE: prdata = 32'(half_life_q);
			default:       prdata = 32'(thr_q);
		endcase
	end

	csd_coef u_coef (
		.clk(clk), .arst_n(arst_n), .start(coef_start),
		.half_life(half_life_q), .time_step(dt_q),
		.done(coef_done), .y(y), .decay(decay)
	);

	genvar g;
	generate
		for (g = 0; g < OUT_LANES; g++) begin : g_lane
			if (g < NUM_LANES) begin : g_on
				logic signed [31:0] p, v;
				csd_lane u_lane (
					.clk(clk), .arst_n(arst_n), .start(lane_start),
					.func(func_q), .hold(hold_q[g]), .target(tgt_q[32*g +: 32]),
					.time_step(dt_q), .threshold(thr_q), .y(y), .decay(decay),
					.done(lane_done[g]), .pos(p), .vel(v)
				);
				assign pos_w[g] = p;
				assign vel_w[g] = v;
			end else begin : g_off
				assign pos_w[g] = '0;
				assign vel_w[g] = '0;
			end
		end
	endgenerate

	// merge lane results into one output word
	assign result = {vel_w[2], vel_w[1], vel_w[0], pos_w[2], pos_w[1], pos_w[0]};
	assign all_done = &(ldone_q | lane_done);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= T_IDLE;
			out_valid_q <= 1'b0;
			ldone_q     <= '0;
		end else begin
			state_q <= state_d;
			if (lane_start)
				ldone_q <= '0;
			else if (state_q == T_LANE)
				ldone_q <= ldone_q | lane_done;
			if (load_out)
				out_valid_q <= 1'b1;
			else if (m_axis_tready)
				out_valid_q <= 1'b0;
		end
	end

	// sequence: accept, coefficients, lanes, hand off to the output register
	always_comb begin
		state_d       = state_q;
		s_axis_tready = 1'b0;
		coef_start    = 1'b0;
		lane_start    = 1'b0;
		load_out      = 1'b0;
		unique case (state_q)
			T_IDLE: begin
				s_axis_tready = 1'b1;
				if (s_axis_tvalid) begin
					coef_start = 1'b1;
					state_d    = T_COEF;
				end
			end
			T_COEF: if (coef_done) begin
				lane_start = 1'b1;
				state_d    = T_LANE;
			end
			T_LANE: if (all_done)
				state_d = T_PUSH;
			T_PUSH: if (!out_valid_q || m_axis_tready) begin
				load_out = 1'b1;
				state_d  = T_IDLE;
			end
			default: state_d = T_IDLE;
		endcase
	end

	// capture the item and the result word
	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			tgt_q  <= s_axis_tdata[95:0];
			dt_q   <= s_axis_tdata[111:96];
			hold_q <= s_axis_tdata[114:112];
			func_q <= s_axis_tuser[0];
		end
		if (load_out)
			out_q <= result;
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_q;

endmodule
`default_nettype wire

// ===== hdl/csd_check.sv =====
`default_nettype none
module csd_check (
	input wire logic         clk,
	input wire logic         arst_n,
	input wire logic         s_axis_tvalid,
	input wire logic         s_axis_tready,
	input wire logic         m_axis_tvalid,
	input wire logic         m_axis_tready,
	input wire logic [191:0] m_axis_tdata,
	input wire logic         pready
);

	// one item at a time: no accept right after an accept
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
		else $error("input accepted twice in a row");

	// a stalled result stays and holds its data
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
		else $error("stalled result changed");

	// a new result only appears as the block returns to idle
	a_out_rise: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> s_axis_tready)
		else $error("result appeared while busy");

	a_pready: assert property (@(posedge clk) disable iff (!arst_n) pready)
		else $error("pready low");

endmodule

bind critically_damped_spring_step csd_check u_csd_check (.*);
`default_nettype wire

// ===== dv/tb.sv =====
`default_nettype none
class spring_scoreboard;
	logic [23:0] half_life;
	logic [15:0] threshold;
	logic signed [31:0] lane_pos [3];
	logic signed [31:0] lane_vel [3];
	logic [191:0] pending [$];
	int errors;

	function new();
		half_life = csd_pkg::HALF_LIFE_RST;
		threshold = csd_pkg::THRESH_RST;
		errors = 0;
		foreach (lane_pos[i]) begin
			lane_pos[i] = 0;
			lane_vel[i] = 0;
		end
	endfunction

	// floor(a*b / 2^s) with magnitude capped at 2^61
	function logic [63:0] mul_cap(logic [63:0] a, logic [63:0] b, int s);
		logic [127:0] p;
		p = ({64'd0, a} * {64'd0, b}) >> s;
		if (p > 128'(csd_pkg::MAG_CAP))
			return csd_pkg::MAG_CAP;
		return p[63:0];
	endfunction

	// signed product: magnitude times magnitude, then sign
	function logic signed [63:0] smul(logic signed [63:0] a, logic [63:0] b, int s);
		logic [63:0] m;
		m = a[63] ? 64'(-a) : 64'(a);
		m = mul_cap(m, b, s);
		return a[63] ? -$signed(m) : $signed(m);
	endfunction

	function logic signed [31:0] clip32(logic signed [63:0] v);
		if (v > 64'sd2147483647)
			return 32'sh7FFFFFFF;
		if (v < -64'sd2147483648)
			return 32'sh80000000;
		return v[31:0];
	endfunction

	// advance the lanes by one accepted item and queue the new state
	function void note_item(logic func, logic [119:0] d);
		logic [63:0] y, x, x2, x3, poly, decay, dt;
		logic signed [63:0] t, j0, j1, sep, a, b, thr, vel;
		logic [2:0] hold;
		logic [191:0] res;
		dt = 64'(d[111:96]);
		hold = d[114:112];
		thr = 64'(threshold);
		y = csd_pkg::LN2X2_Q24 / (64'(half_life) + 1);
		x = mul_cap(y, dt, 16);
		if (x > csd_pkg::X_MAX_Q24)
			x = csd_pkg::X_MAX_Q24;
		x2 = mul_cap(x, x, 24);
		x3 = mul_cap(x2, x, 24);
		poly = csd_pkg::ONE_Q24 + x + mul_cap(x2, csd_pkg::C048_Q24, 24)
			+ mul_cap(x3, csd_pkg::C0235_Q24, 24);
		decay = csd_pkg::DECAY_NUM / poly;
		for (int i = 0; i < 3; i++) begin
			t = 64'($signed(d[32*i +: 32]));
			vel = 64'(lane_vel[i]);
			if (!hold[i]) begin
				if (func) begin
					lane_pos[i] = t[31:0];
					lane_vel[i] = 0;
				end else begin
					j0 = 64'(lane_pos[i]) - t;
					sep = j0 < 0 ? -j0 : j0;
					if (!(sep < thr && vel < thr)) begin
						j1 = vel + smul(j0, y, 24);
						a = j0 + smul(j1, dt, 16);
						b = vel - smul(smul(j1, y, 24), dt, 16);
						lane_pos[i] = clip32(smul(a, decay, 32) + t);
						lane_vel[i] = clip32(smul(b, decay, 32));
					end
				end
			end
			res[32*i +: 32] = lane_pos[i];
			res[96 + 32*i +: 32] = lane_vel[i];
		end
		pending.push_back(res);
	endfunction

	function void check_result(logic [191:0] got);
		logic [191:0] exp_res;
		if (pending.size() == 0) begin
			$display("%0t: unexpected result %h", $time, got);
			errors++;
			return;
		end
		exp_res = pending.pop_front();
		for (int f = 0; f < 6; f++)
			if (got[32*f +: 32] !== exp_res[32*f +: 32]) begin
				$display("%0t: field %0d expected %h actual %h", $time, f,
					exp_res[32*f +: 32], got[32*f +: 32]);
				errors++;
			end
	endfunction
endclass

module tb;
	timeunit 1ns;
	timeprecision 1ps;

	logic clk = 0, arst_n = 0;
	logic s_axis_tvalid = 0, s_axis_tready;
	logic [119:0] s_axis_tdata = '0;
	logic [0:0] s_axis_tuser = '0;
	logic m_axis_tvalid, m_axis_tready = 0;
	logic [191:0] m_axis_tdata;
	logic psel = 0, penable = 0, pwrite = 0;
	logic [2:0] paddr = '0;
	logic [31:0] pwdata = '0, prdata;
	logic pready;
	logic rx_hold = 0;
	logic stim_done = 0;
	int cycles = 0;
	spring_scoreboard sb = new();

	critically_damped_spring_step dut (.*);

	always begin
		#1 clk = 1;
		#1 clk = 0;
	end

	// note accepted items and check results at the rising edge
	always @(posedge clk) begin
		if (arst_n && s_axis_tvalid && s_axis_tready)
			sb.note_item(s_axis_tuser[0], s_axis_tdata);
		if (arst_n && m_axis_tvalid && m_axis_tready)
			sb.check_result(m_axis_tdata);
	end

	// receiver: random stalls, mostly short, a long hold-off when asked
	initial begin
		int gap;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (rx_hold) begin
				m_axis_tready <= 0;
			end else begin
				gap = $urandom_range(0, 9) == 0 ? $urandom_range(20, 400)
					: ($urandom_range(0, 2) == 0 ? $urandom_range(1, 4) : 0);
				m_axis_tready <= gap == 0;
				if (gap != 0) begin
					repeat (gap) @(negedge clk);
					m_axis_tready <= 1;
				end
			end
		end
	end

	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > 3000000) begin
				$display("tb NOT OK");
				$finish;
			end
		end
	end

	task automatic reg_write(logic idx, logic [31:0] val);
		@(negedge clk);
		psel <= 1; pwrite <= 1; penable <= 0;
		paddr <= 3'(idx) << 2; pwdata <= val;
		@(negedge clk);
		penable <= 1;
		@(negedge clk);
		psel <= 0; penable <= 0; pwrite <= 0;
		if (idx == csd_pkg::REG_HALF_LIFE)
			sb.half_life = val[23:0];
		else
			sb.threshold = val[15:0];
	endtask

	// offer one item and hold it until the transfer
	task automatic send_item(logic func, logic signed [31:0] tx, logic signed [31:0] ty,
			logic signed [31:0] tz, logic [15:0] dt, logic [2:0] hold, bit gaps);
		if (gaps && $urandom_range(0, 3) == 0)
			repeat ($urandom_range(0, 9) == 0 ? $urandom_range(20, 300)
				: $urandom_range(1, 3)) @(negedge clk);
		else
			@(negedge clk);
		s_axis_tvalid <= 1;
		s_axis_tuser <= func;
		s_axis_tdata <= {5'd0, hold, dt, tz, ty, tx};
		do @(posedge clk); while (!s_axis_tready);
		@(negedge clk);
		s_axis_tvalid <= 0;
	endtask

	task automatic drain();
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (300) @(negedge clk);
	endtask

	function automatic logic signed [31:0] rand_val();
		case ($urandom_range(0, 5))
			0: return 32'sh7FFFFFFF;
			1: return 32'sh80000000;
			2: return $signed(32'($urandom_range(0, 2000)) - 1000);
			default: return $urandom;
		endcase
	endfunction

	initial begin
		logic [23:0] hl_set [6];
		logic [15:0] th_set [6];
		hl_set = '{24'd6554, 24'd1, 24'hFFFFFF, 24'd65536, 24'd300, 24'd2000000};
		th_set = '{16'd7, 16'd0, 16'hFFFF, 16'd100, 16'd3, 16'd40000};
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// directed: snaps, extremes, holds, resting lanes
		send_item(1, 32'sh7FFFFFFF, 32'sh80000000, 0, 16'hFFFF, 3'd0, 0);
		send_item(0, 32'sh80000000, 32'sh7FFFFFFF, 0, 16'hFFFF, 3'd0, 0);
		send_item(0, 0, 0, 0, 16'd0, 3'd7, 0);
		send_item(1, 32'sd100, 32'sd5, -32'sd5, 16'd0, 3'd5, 0);
		send_item(0, 32'sd103, 32'sd6, -32'sd3, 16'd1000, 3'd0, 0);
		send_item(0, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh80000000, 16'd1, 3'd2, 0);
		send_item(1, 32'sh55555555, -32'sh2AAAAAAB, 32'sh12345678, 16'd0, 3'd0, 0);
		send_item(0, 0, 0, 0, 16'd32768, 3'd0, 0);
		drain();
		reg_write(csd_pkg::REG_HALF_LIFE, 32'd1);
		reg_write(csd_pkg::REG_THRESHOLD, 32'hFFFF);
		send_item(0, 32'sd1000, -32'sd1000, 32'sh7FFFFFFF, 16'hFFFF, 3'd0, 0);
		send_item(0, 32'sh80000000, 32'sd70000, 0, 16'd1, 3'd0, 0);
		drain();
		reg_write(csd_pkg::REG_HALF_LIFE, 32'hFFFFFF);
		reg_write(csd_pkg::REG_THRESHOLD, 32'd0);
		send_item(0, 32'sh7FFFFFFF, 32'sh80000000, 32'sd1, 16'hFFFF, 3'd0, 0);
		send_item(0, 32'sh80000000, 32'sh7FFFFFFF, 32'sd1, 16'hFFFF, 3'd0, 0);
		drain();

		// random phases over several register settings
		for (int ph = 0; ph < 6; ph++) begin
			reg_write(csd_pkg::REG_HALF_LIFE, 32'(hl_set[ph]));
			reg_write(csd_pkg::REG_THRESHOLD, 32'(th_set[ph]));
			if (ph == 2)
				rx_hold <= 1;
			for (int k = 0; k < 173; k++) begin
				if (ph == 2 && k == 0) begin
					// release the long hold-off after the input has stalled
					fork
						begin
							repeat (2000) @(negedge clk);
							rx_hold <= 0;
						end
					join_none
				end
				send_item($urandom_range(0, 7) == 0, rand_val(), rand_val(), rand_val(),
					$urandom_range(0, 3) == 0 ? 16'($urandom) : 16'($urandom_range(0, 3000)),
					$urandom_range(0, 3) == 0 ? 3'($urandom) : 3'd0, 1);
			end
			drain();
		end
		if (sb.errors == 0)
			$display("tb OK");
		else
			$display("tb NOT OK");
		$finish;
	end
endmodule
`default_nettype wire

// ===== filelist.f =====
hdl/csd_pkg.sv
hdl/csd_mul.sv
hdl/csd_div.sv
hdl/csd_coef.sv
hdl/csd_lane.sv
hdl/critically_damped_spring_step.sv
hdl/csd_check.sv
dv/tb.sv
